@@ rtl/atsc_pkg.sv @@
package atsc_pkg;

	// One input item: tick duration, target angle and target speed.
	typedef struct packed {
		logic        [15:0] tick_time;
		logic        [15:0] target_angle;
		logic signed [23:0] target_speed;
	} tick_t;

	// One result item.
	typedef struct packed {
		logic signed [23:0] drive_speed_out;
		logic        [15:0] estimated_angle;
		logic        [15:0] error_magnitude;
		logic               is_leading;
		logic               fast_mode;
	} result_t;

	localparam int unsigned PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// Error at or above this many angle units (0.05 turn) selects full speed.
	localparam logic [15:0] FAST_LIMIT = 16'd3277;
	localparam logic [15:0] HALF_TURN  = 16'd32768;
	// ceil(2^28 / 5): exact reciprocal of five for dividends below 2^26.
	localparam logic [25:0] RECIP_5    = 26'd53687092;
	localparam int unsigned RECIP_SH   = 28;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_MUL_STEP,
		OP_EST,
		OP_CMP,
		OP_MUL_LAG,
		OP_LAG,
		OP_MUL_LEAD,
		OP_LEAD,
		OP_FAST,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_FAST,
		COND_LEAD,
		COND_IN,
		COND_OUT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	localparam pc_t PC_LAST = 4'd9;

	// Microprogram: one control word per step.
	function automatic ctrl_t ucode_rom(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			4'd0:    w = '{OP_WAIT,     COND_IN,   4'd1};
			4'd1:    w = '{OP_MUL_STEP, COND_NEXT, 4'd0};
			4'd2:    w = '{OP_EST,      COND_NEXT, 4'd0};
			4'd3:    w = '{OP_CMP,      COND_FAST, 4'd8};
			4'd4:    w = '{OP_MUL_LAG,  COND_LEAD, 4'd6};
			4'd5:    w = '{OP_LAG,      COND_JUMP, 4'd9};
			4'd6:    w = '{OP_MUL_LEAD, COND_NEXT, 4'd0};
			4'd7:    w = '{OP_LEAD,     COND_JUMP, 4'd9};
			4'd8:    w = '{OP_FAST,     COND_NEXT, 4'd0};
			4'd9:    w = '{OP_OUT,      COND_OUT,  4'd0};
			default: w = '{OP_WAIT,     COND_JUMP, 4'd0};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/atsc_stream_if.sv @@
interface atsc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/angle_tracking_speed_controller_top.sv @@
// Angle tracking speed controller. Each input item on the tick channel carries the time
// since the last tick (unsigned Q0.16 seconds), a target angle (16-bit fraction of a turn)
// and a target speed (signed, 1/65536 turn per second). The block moves its estimated angle
// back by the current drive speed times the tick time, measures the error to the target,
// decides whether the estimate leads or lags, and returns one result item holding the new
// drive speed, the updated estimate, the error magnitude and the leading and fast-mode flags.
// Errors above 0.05 turn give plus or minus max_speed; otherwise a leading estimate gets
// 0.8 times the target speed and a lagging one is pushed toward max_speed in proportion to
// the error. The max_speed register is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce. It resets
// to zero together with the angle estimate and the drive speed. Control is a ten-step
// microprogram in a small read-only table sharing one 27 by 27 bit signed multiplier.
// tick.ready is high only in the wait step. After an item is taken the multiplier forms
// the angle step, the estimate is updated and the error compared; then either the fast
// step sets the speed, or the multiplier forms the speed product and the speed is updated;
// the output step ends the item. Each multiplier use is followed by a register. The leading
// path forms the lagging product first and then replaces it with its own. The result item
// sits in an output register, so the next item is accepted while the previous result still
// waits; a stalled result delays only the final step of the following item.
module angle_tracking_speed_controller_top
	import atsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [22:0]          cfg_wdata,
	atsc_stream_if.sink          tick,
	atsc_stream_if.source        result
);

	// Sequencer state.
	pc_t   pc_q;
	pc_t   pc_d;
	ctrl_t ctrl;

	// Configuration and tracking state.
	logic        [22:0] max_speed_q;
	logic        [15:0] pos_q;
	logic signed [23:0] cur_speed_q;

	// Captured item.
	logic        [15:0] tick_time_q;
	logic        [15:0] target_q;
	logic signed [23:0] tspeed_q;

	// Error analysis.
	logic [15:0] mag_q;
	logic        lead_q;
	logic        fast_q;

	// Shared multiplier.
	logic signed [26:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [53:0] mul_p;
	logic signed [53:0] prod_q;
	logic signed [53:0] prod_rnd;

	// Output register.
	logic    out_valid_q;
	result_t out_data_q;
	logic    out_free;
	logic    in_accept;

	// Combinational helpers.
	logic        [15:0] mag_c;
	logic               lead_c;
	logic               fast_c;
	logic signed [25:0] diff_c;
	logic        [20:0] mag20_c;
	logic        [25:0] n_c;
	logic        [25:0] abs_n_c;
	logic        [25:0] x_c;
	logic        [23:0] quot_c;

	assign ctrl      = ucode_rom(pc_q);
	assign in_accept = tick.valid && tick.ready;
	assign out_free  = !out_valid_q || result.ready;

	assign tick.ready   = (ctrl.op == OP_WAIT);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// Error magnitude is a plain difference; beyond half a turn the direction flips.
	always_comb begin
		mag_c  = (target_q > pos_q) ? (target_q - pos_q) : (pos_q - target_q);
		lead_c = (mag_c > HALF_TURN) ? (pos_q > target_q) : (target_q > pos_q);
		fast_c = (mag_c >= FAST_LIMIT);
	end

	// Operands for the lagging and leading speed paths.
	always_comb begin
		diff_c  = $signed({3'b000, max_speed_q}) - 26'(tspeed_q);
		mag20_c = {1'b0, mag_q, 4'b0000} + {3'b000, mag_q, 2'b00};
		n_c     = {tspeed_q, 2'b00};
		abs_n_c = tspeed_q[23] ? (26'd0 - n_c) : n_c;
		x_c     = abs_n_c + 26'd2;
		quot_c  = prod_q[RECIP_SH+23:RECIP_SH];
	end

	always_comb begin
		unique case (ctrl.op)
			OP_MUL_STEP: begin
				mul_a = 27'(cur_speed_q);
				mul_b = $signed({11'd0, tick_time_q});
			end
			OP_MUL_LAG: begin
				mul_a = 27'(diff_c);
				mul_b = $signed({6'd0, mag20_c});
			end
			OP_MUL_LEAD: begin
				mul_a = $signed({1'b0, x_c});
				mul_b = $signed({1'b0, RECIP_5});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	// Round to nearest with ties upward: add half an LSB of the 16-bit shift.
	assign prod_rnd = prod_q + 54'sd32768;

	always_comb begin
		unique case (ctrl.cond)
			COND_NEXT: pc_d = pc_q + pc_t'(1);
			COND_JUMP: pc_d = ctrl.target;
			COND_FAST: pc_d = fast_c ? ctrl.target : pc_q + pc_t'(1);
			COND_LEAD: pc_d = lead_q ? ctrl.target : pc_q + pc_t'(1);
			COND_IN:   pc_d = in_accept ? pc_q + pc_t'(1) : pc_q;
			COND_OUT:  pc_d = out_free ? ctrl.target : pc_q;
			default:   pc_d = '0;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			max_speed_q <= '0;
			pos_q       <= '0;
			cur_speed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_we) begin
				max_speed_q <= cfg_wdata;
			end
			if (ctrl.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				OP_EST:  pos_q <= pos_q - prod_rnd[31:16];
				OP_LAG:  cur_speed_q <= tspeed_q + prod_rnd[39:16];
				OP_LEAD: cur_speed_q <= tspeed_q[23] ? -$signed(quot_c) : $signed(quot_c);
				OP_FAST: cur_speed_q <= lead_q ? -$signed({1'b0, max_speed_q})
				                               :  $signed({1'b0, max_speed_q});
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_time_q <= tick.data.tick_time;
			target_q    <= tick.data.target_angle;
			tspeed_q    <= tick.data.target_speed;
		end
		if (ctrl.op == OP_MUL_STEP || ctrl.op == OP_MUL_LAG || ctrl.op == OP_MUL_LEAD) begin
			prod_q <= mul_p;
		end
		if (ctrl.op == OP_CMP) begin
			mag_q  <= mag_c;
			lead_q <= lead_c;
			fast_q <= fast_c;
		end
		if (ctrl.op == OP_OUT && out_free) begin
			out_data_q.drive_speed_out <= cur_speed_q;
			out_data_q.estimated_angle <= pos_q;
			out_data_q.error_magnitude <= mag_q;
			out_data_q.is_leading      <= lead_q;
			out_data_q.fast_mode       <= fast_q;
		end
	end

	// The sequencer leaves the wait step right after taking an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !tick.ready)
		else $error("tick.ready high right after an accepted item");

	// A new result is only ever loaded by the output step.
	a_load_from_out_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op == OP_OUT))
		else $error("result became valid outside the output step");

	// Fast mode is only reported for errors at or above the threshold.
	a_fast_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.fast_mode) |-> (out_data_q.error_magnitude >= FAST_LIMIT))
		else $error("fast mode reported below threshold");

	// The step counter never leaves the program.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST)
		else $error("step counter outside the microprogram");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb
	import atsc_pkg::*;
();

	// Cycles to wait after the last result before a register write or the end of the run.
	localparam int SETTLE_CYCLES = 20;
	// Cycles without any accepted item before the run is declared hung. The longest
	// legal gap is the long receiver hold-off below, well under this.
	localparam int HANG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS = 210;
	localparam int MAX_PRINTED = 50;

	// Idling mixes; the sender and receiver percentages are applied per cycle.
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [22:0] cfg_wdata;

	atsc_stream_if #(.payload_t(tick_t))   tick_ch ();
	atsc_stream_if #(.payload_t(result_t)) result_ch ();

	angle_tracking_speed_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.result    (result_ch)
	);

	// Items waiting to be offered and results the block still owes us.
	tick_t   pending_ticks[$];
	result_t expected_results[$];

	// Controller state as the checker sees it, advanced on every accepted item.
	logic        [15:0] live_est;
	logic signed [23:0] live_speed;
	logic        [22:0] live_max_speed;

	// A second copy used only while building stimulus, so that targets can be placed
	// relative to where the estimate will be when the item is processed.
	logic        [15:0] plan_est;
	logic signed [23:0] plan_speed;
	logic        [22:0] plan_max_speed;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_seq;
	int hold_len;
	int error_count;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Computes the result of one tick from the estimate and drive speed left by the
	// previous tick. The new estimate and speed are the result's own fields.
	function automatic result_t track_tick(input logic [15:0] est_in,
			input logic signed [23:0] speed_in, input tick_t item,
			input logic [22:0] max_spd);
		longint  prod;
		longint  step;
		longint  num;
		longint  drive;
		longint  tgt_spd;
		logic [15:0] est;
		logic [15:0] mag;
		logic    lead;
		logic    fast;
		result_t res;

		tgt_spd = longint'($signed(item.target_speed));

		// The estimate falls back by speed times time, rounded half up to whole units.
		prod = longint'($signed(speed_in)) * longint'(item.tick_time);
		step = (prod + 32768) >>> 16;
		est = est_in - step[15:0];

		// Error is a plain difference; past half a turn the sense of direction flips.
		mag = (item.target_angle > est) ? item.target_angle - est : est - item.target_angle;
		if (mag > HALF_TURN)
			lead = est > item.target_angle;
		else
			lead = item.target_angle > est;
		fast = (longint'(mag) * 20) > 65536;

		if (fast) begin
			drive = lead ? -longint'(max_spd) : longint'(max_spd);
		end else if (lead) begin
			// Four fifths of the target speed, rounded to nearest, symmetric about zero.
			num = tgt_spd * 4;
			if (num >= 0)
				drive = (num + 2) / 5;
			else
				drive = -((-num + 2) / 5);
		end else begin
			// Pull toward max_speed in proportion to the error over the threshold.
			num = (longint'(max_spd) - tgt_spd) * longint'(mag) * 20;
			drive = tgt_spd + ((num + 32768) >>> 16);
		end

		res.drive_speed_out = drive[23:0];
		res.estimated_angle = est;
		res.error_magnitude = mag;
		res.is_leading      = lead;
		res.fast_mode       = fast;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		// Only the first few are printed so a badly broken block cannot flood the log.
		if (error_count <= MAX_PRINTED)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Sender: offers the next pending item, or idles at the current rate. The prediction
	// is made at the accepting edge, from the state the block has at that point.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tick_ch.data  <= '0;
		end else begin
			if (tick_ch.valid && tick_ch.ready) begin
				result_t r;
				r = track_tick(live_est, live_speed, tick_ch.data, live_max_speed);
				live_est   = r.estimated_angle;
				live_speed = r.drive_speed_out;
				expected_results.push_back(r);
			end
			if (!tick_ch.valid || tick_ch.ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					tick_ch.valid <= 1'b1;
					tick_ch.data  <= pending_ticks.pop_front();
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls at the current rate. A new hold request from the stimulus
	// process makes it hold ready low for a counted stretch of cycles.
	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		int hold_seen;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checker: every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, drive speed",
					longint'($signed(got.drive_speed_out)), 0);
			end else begin
				want = expected_results.pop_front();
				if (got.drive_speed_out !== want.drive_speed_out)
					report_mismatch("drive_speed_out", longint'($signed(got.drive_speed_out)),
						longint'($signed(want.drive_speed_out)));
				if (got.estimated_angle !== want.estimated_angle)
					report_mismatch("estimated_angle", got.estimated_angle,
						want.estimated_angle);
				if (got.error_magnitude !== want.error_magnitude)
					report_mismatch("error_magnitude", got.error_magnitude,
						want.error_magnitude);
				if (got.is_leading !== want.is_leading)
					report_mismatch("is_leading", got.is_leading, want.is_leading);
				if (got.fast_mode !== want.fast_mode)
					report_mismatch("fast_mode", got.fast_mode, want.fast_mode);
			end
		end
	end

	// Watchdog: ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Writes max_speed. Only called with the block idle, so the model can switch at once.
	task automatic write_max_speed(input logic [22:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		live_max_speed = value;
		plan_max_speed = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until everything queued has been sent and answered, then lets the block settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || tick_ch.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Queues one tick. With rel set, the target is placed so that its raw difference to
	// the estimate the block will hold equals the offset, wherever that stays in range;
	// otherwise the offset is applied the other way. Without rel, the offset is the target.
	task automatic add_tick(input int dt, input int offset, input int spd, input bit rel);
		tick_t   item;
		result_t r;
		int      e;
		item.tick_time    = dt[15:0];
		item.target_angle = 16'd0;
		item.target_speed = spd[23:0];
		if (rel) begin
			r = track_tick(plan_est, plan_speed, item, plan_max_speed);
			e = int'(r.estimated_angle);
			if (e + offset >= 0 && e + offset <= 65535)
				item.target_angle = 16'(e + offset);
			else
				item.target_angle = 16'(e - offset);
		end else begin
			item.target_angle = offset[15:0];
		end
		r = track_tick(plan_est, plan_speed, item, plan_max_speed);
		plan_est   = r.estimated_angle;
		plan_speed = r.drive_speed_out;
		pending_ticks.push_back(item);
	endtask

	// Random tick. Most targets land close to the estimate, so the tracking loop spends
	// real time in the normal-mode branches and around the fast-mode threshold.
	task automatic add_random_tick();
		int dt;
		int off;
		int spd;
		int pick;
		pick = $urandom_range(99);
		dt = (pick < 70) ? $urandom_range(1500) : int'($urandom_range(65535));
		spd = ($urandom_range(1) == 0) ? int'($urandom) :
			int'($urandom_range(400000)) - 200000;
		pick = $urandom_range(99);
		if (pick < 60)
			add_tick(dt, int'($urandom_range(6800)) - 3400, spd, 1'b1);
		else if (pick < 75)
			add_tick(dt, int'($urandom_range(80)) - 40, spd, 1'b1);
		else if (pick < 85)
			add_tick(dt, int'($urandom_range(65535)) - 32768, spd, 1'b1);
		else
			add_tick(dt, int'($urandom_range(65535)), spd, 1'b0);
	endtask

	initial begin
		logic [22:0] max_values[8];
		int          mode;

		// Every input of the block is known from time zero; reset is asserted from the start.
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.data    = '0;
		result_ch.ready = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_seq        = 0;
		hold_len        = 0;
		error_count     = 0;
		idle_cycles     = 0;
		live_est        = '0;
		live_speed      = '0;
		live_max_speed  = '0;
		plan_est        = '0;
		plan_speed      = '0;
		plan_max_speed  = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ticks. The first ones run with max_speed still at its reset value.
		add_tick(0, 0, 0, 1'b1);                  // equal angles from reset: lagging, no error
		add_tick(65535, 65535, 8388607, 1'b0);    // largest target, beyond half a turn
		wait_drained();
		write_max_speed(23'd200000);
		add_tick(65535, 65535, 8388607, 1'b0);    // direction flip, fast while lagging
		add_tick(65535, 0, -8388608, 1'b1);       // longest step, equal angles, lowest speed
		add_tick(1, 100, 8388607, 1'b1);          // leading in normal mode, top speed
		add_tick(100, -100, -8388608, 1'b1);      // lagging in normal mode, bottom speed
		add_tick(0, 100, 0, 1'b1);                // leading with zero target speed
		add_tick(0, 3276, 1234567, 1'b1);         // largest error that stays in normal mode
		add_tick(0, 3277, -1234567, 1'b1);        // smallest error that selects full speed
		add_tick(0, -3276, 7654321, 1'b1);
		add_tick(0, -3277, -7654321, 1'b1);
		add_tick(0, 32768, 1000, 1'b1);           // exactly half a turn: no flip
		add_tick(0, -32768, -1000, 1'b1);
		add_tick(0, 32769, 5, 1'b1);              // just past half a turn: flip
		add_tick(0, -32769, -5, 1'b1);
		add_tick(0, 60000, 3, 1'b1);
		add_tick(0, 0, 0, 1'b0);                  // target at the bottom of the turn
		add_tick(40000, 65535, 2, 1'b0);
		add_tick(65535, 0, 8388607, 1'b1);
		add_tick(1, -1, -1, 1'b1);
		wait_drained();

		max_values[0] = 23'h7FFFFF;
		max_values[1] = 23'd0;
		max_values[2] = 23'd1;
		max_values[3] = 23'($urandom);
		max_values[4] = 23'd65536;
		max_values[5] = 23'h400000;
		max_values[6] = 23'($urandom);
		max_values[7] = 23'd3000;

		// Two register settings under each idling mix.
		for (int ph = 0; ph < 8; ph++) begin
			mode = ph / 2;
			write_max_speed(max_values[ph]);
			send_idle_pct  = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 8 : 0;
			recv_stall_pct = (mode == IDLE_RECV) ? 65 : (mode == IDLE_BOTH) ? 8 : 0;
			for (int i = 0; i < PHASE_ITEMS / 2; i++)
				add_random_tick();
			if (ph == 0) begin
				// Hold the receiver off while items keep coming, so the block backs up.
				hold_len = HOLD_OFF_CYCLES;
				hold_seq++;
			end
			if (ph == 4) begin
				// The sender pauses here until every result has been returned.
				wait_drained();
			end
			for (int i = 0; i < PHASE_ITEMS - PHASE_ITEMS / 2; i++)
				add_random_tick();
			wait_drained();
		end

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/atsc_pkg.sv
rtl/atsc_stream_if.sv
rtl/angle_tracking_speed_controller_top.sv
bench/tb.sv
